[design/arq_receiver_window_assert.svh]
// assertion macros for the arq receiver window
`ifndef ARQ_RECEIVER_WINDOW_ASSERT_SVH
`define ARQ_RECEIVER_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
`define ARQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arq receiver window assertion failed");
`define ARQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arq receiver window assertion failed");
`else
`define ARQ_ASSERT_IMP(lbl, ante, cons)
`define ARQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/arqrw_pkg.sv]
// shared types and constants of the arq receiver window
package arqrw_pkg;

  localparam int SEQ_W   = 10;
  localparam int LEN_W   = 10;
  localparam int ACK_W   = 11;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 32;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int POS_W   = 6;
  localparam int SUM_W   = 12;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 176;
  localparam int SEQ_LIMIT = 1 << SEQ_W;

  localparam logic [1:0] MODE_SW  = 2'd0;
  localparam logic [1:0] MODE_GBN = 2'd1;

  localparam logic REG_ARQ_MODE      = 1'b0;
  localparam logic REG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [2:0] LIMIT_RESET = 3'd5;
  localparam logic [2:0] RUN_MAX     = 3'd7;
  localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_WR   = 6'b000100,
    S_SRD  = 6'b001000,
    S_SCAN = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

[design/arq_receiver_window.sv]
// arq receiver window: expected number, received bitmap and statistics
// One item at a time. Timeouts, invalid packets, stop-and-wait packets and
// packets that mark nothing go from the execute state to the finish state.
// A go-back-N or selective-repeat packet that is stored goes on through the
// write, read-wait and scan states; the scan reads the 32-bit bitmap words of
// the in-order advance one word per cycle from the registered bitmap memory,
// and the read-wait state lies between the marking write and the first read.
// Bitmap rows carry valid flags cleared by reset, so the block is ready
// straight after reset with no clearing pass. The next item is accepted while
// a finished result still waits in the output register.
`include "arq_receiver_window_assert.svh"

module arq_receiver_window #(
  parameter int SEQ_SPACE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [2:0]                  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // packet_ok, seq_num, data_length, zero pad
  input  logic [arqrw_pkg::IN_W-1:0]  s_tdata,
  // op
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // ack_valid, ack_num, deliver_first, deliver_count, expected_next,
  // misordered, finished, packets_total, corrupted_total,
  // misorder_total, bytes_total, zero pad
  output logic [arqrw_pkg::OUT_W-1:0] m_tdata
);
  import arqrw_pkg::*;

  localparam int MAP_DEPTH = (SEQ_SPACE < SEQ_LIMIT) ? SEQ_SPACE : SEQ_LIMIT;
  localparam int NUM_WORDS = (MAP_DEPTH + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int EXP_W     = $clog2(MAP_DEPTH + 1);

  state_t state;

  logic [1:0]        arq_mode;
  logic [2:0]        timeout_limit;
  logic [EXP_W-1:0]  expected;
  logic [2:0]        timeout_run;
  logic              done;
  logic [STAT_W-1:0] valid_count;
  logic [STAT_W-1:0] bad_count;
  logic [STAT_W-1:0] misorder_count;
  logic [STAT_W-1:0] byte_count;

  logic              i_op;
  logic              i_ok;
  logic [SEQ_W-1:0]  i_seq;
  logic [LEN_W-1:0]  i_len;

  logic              r_ack_v;
  logic [ACK_W-1:0]  r_ack_n;
  logic [SEQ_W-1:0]  r_dfirst;
  logic [CNT_W-1:0]  r_dcount;
  logic              r_ooo;
  logic              r_sr;

  logic [WORD_W-1:0] map_mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_W-1:0] rdata;
  logic              rv_q;
  logic [WIDX_W-1:0] rd_addr;
  logic [WIDX_W-1:0] seq_word;
  logic [WIDX_W-1:0] exp_word;
  logic [WIDX_W:0]   exp_word_inc;
  logic              has_next;
  logic              mem_we;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] wr_data;

  logic              in_space;
  logic              hit;
  logic              seq_ge;
  logic              seq_gt;
  logic [ACK_W-1:0]  ack_prev;
  logic [2:0]        run_inc;
  logic [STAT_W:0]   byte_sum;

  logic [BIT_W-1:0]  off;
  logic [WORD_W-1:0] zeros_above;
  logic [POS_W-1:0]  first_zero;
  logic [POS_W-1:0]  run_len;
  logic [SUM_W-1:0]  exp_sum;
  logic [SEQ_W-1:0]  dfirst_out;

  function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [POS_W-1:0] p;
    p = POS_W'(WORD_W);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  assign s_tready = (state == S_IDLE);

  // bitmap addressing and scan datapath
  assign seq_word     = WIDX_W'(i_seq >> BIT_W);
  assign exp_word     = WIDX_W'(expected >> BIT_W);
  assign exp_word_inc = (WIDX_W + 1)'(exp_word) + 1'b1;
  assign has_next     = (exp_word_inc < (WIDX_W + 1)'(NUM_WORDS));
  assign cur_word     = rv_q ? rdata : '0;
  assign wr_data      = cur_word | (WORD_W'(1) << i_seq[BIT_W-1:0]);
  assign mem_we       = (state == S_WR);

  assign off         = BIT_W'(expected);
  assign zeros_above = ~cur_word & ({WORD_W{1'b1}} << off);
  assign first_zero  = lowest_set(zeros_above);
  assign run_len     = first_zero - POS_W'(off);
  assign exp_sum     = SUM_W'(expected) + SUM_W'(run_len);

  always_comb begin
    unique case (state)
      S_EXEC:  rd_addr = seq_word;
      S_SCAN:  rd_addr = has_next ? exp_word_inc[WIDX_W-1:0] : exp_word;
      default: rd_addr = exp_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[seq_word] <= wr_data;
    rdata <= map_mem[rd_addr];
    rv_q  <= row_valid[rd_addr];
  end

  // packet classification
  assign in_space = (32'(i_seq) < SEQ_SPACE);
  assign hit      = in_space && (SUM_W'(i_seq) == SUM_W'(expected));
  assign seq_ge   = (SUM_W'(i_seq) >= SUM_W'(expected));
  assign seq_gt   = (SUM_W'(i_seq) > SUM_W'(expected));
  assign ack_prev = ACK_W'(SUM_W'(expected) - SUM_W'(1));
  assign run_inc  = (timeout_run < RUN_MAX) ? timeout_run + 3'd1 : timeout_run;
  assign byte_sum = (STAT_W + 1)'(byte_count) + (STAT_W + 1)'(i_len);

  assign dfirst_out = (r_sr && (r_dcount == '0)) ? '0 : r_dfirst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      arq_mode       <= MODE_SW;
      timeout_limit  <= LIMIT_RESET;
      expected       <= '0;
      timeout_run    <= '0;
      done           <= 1'b0;
      valid_count    <= '0;
      bad_count      <= '0;
      misorder_count <= '0;
      byte_count     <= '0;
      row_valid      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ARQ_MODE:      arq_mode      <= cfg_data[1:0];
          REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != S_FIN)) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            i_op  <= s_tuser;
            i_ok  <= s_tdata[0];
            i_seq <= s_tdata[SEQ_W:1];
            i_len <= s_tdata[SEQ_W+LEN_W:SEQ_W+1];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          r_ack_v  <= 1'b0;
          r_ack_n  <= '0;
          r_dfirst <= '0;
          r_dcount <= '0;
          r_ooo    <= 1'b0;
          r_sr     <= 1'b0;
          state    <= S_FIN;
          if (!done) begin
            if (i_op) begin
              if (arq_mode == MODE_SW) begin
                timeout_run <= run_inc;
                if (run_inc >= timeout_limit) done <= 1'b1;
              end
            end else begin
              timeout_run <= '0;
              if (!i_ok) begin
                if (bad_count != STAT_MAX) bad_count <= bad_count + 1'b1;
              end else begin
                if (valid_count != STAT_MAX) valid_count <= valid_count + 1'b1;
                byte_count <= byte_sum[STAT_W] ? STAT_MAX : byte_sum[STAT_W-1:0];
                if (arq_mode == MODE_SW) begin
                  r_ack_v <= 1'b1;
                  if (hit) begin
                    r_ack_n  <= ACK_W'(i_seq);
                    r_dfirst <= i_seq;
                    r_dcount <= CNT_W'(1);
                    expected <= expected + 1'b1;
                  end else begin
                    r_ooo   <= 1'b1;
                    r_ack_n <= ack_prev;
                    if (misorder_count != STAT_MAX)
                      misorder_count <= misorder_count + 1'b1;
                  end
                end else if (arq_mode == MODE_GBN) begin
                  if (hit) begin
                    r_ack_v  <= 1'b1;
                    r_ack_n  <= ACK_W'(i_seq);
                    r_dfirst <= i_seq;
                    state    <= S_WR;
                  end else begin
                    r_ooo <= 1'b1;
                    if (misorder_count != STAT_MAX)
                      misorder_count <= misorder_count + 1'b1;
                    if (seq_gt) begin
                      r_ack_v <= 1'b1;
                      r_ack_n <= ack_prev;
                    end
                  end
                end else begin
                  r_ack_v <= 1'b1;
                  r_ack_n <= ACK_W'(i_seq);
                  if (seq_ge) begin
                    if (in_space) begin
                      r_dfirst <= SEQ_W'(expected);
                      r_sr     <= 1'b1;
                      state    <= S_WR;
                    end
                  end else begin
                    r_ooo <= 1'b1;
                    if (misorder_count != STAT_MAX)
                      misorder_count <= misorder_count + 1'b1;
                  end
                end
              end
            end
          end
        end
        S_WR: begin
          row_valid[seq_word] <= 1'b1;
          state <= S_SRD;
        end
        S_SRD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          expected <= EXP_W'(exp_sum);
          r_dcount <= r_dcount + CNT_W'(run_len);
          if (!((first_zero == POS_W'(WORD_W)) && has_next)) state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, byte_count, misorder_count, bad_count, valid_count,
                         done, r_ooo, CNT_W'(expected), r_dcount, dfirst_out,
                         r_ack_n, r_ack_v};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ARQ_ASSERT_IMP(a_done_sticky, !$past(rst) && $past(done), done)
  `ARQ_ASSERT_IMP(a_expected_monotonic, !$past(rst), expected >= $past(expected))
  `ARQ_ASSERT_IMP(a_done_only_sw, !$past(rst) && !$past(done) && done, $past(arq_mode) == MODE_SW)
  `ARQ_ASSERT_IMP(a_scan_in_range, state == S_SCAN, 32'(expected) < MAP_DEPTH)
  `ARQ_ASSERT_NEXT(a_write_then_read, state == S_WR, state == S_SRD)

endmodule

[test/arq_receiver_window_tb.sv]
// self-checking testbench for the arq receiver window, with a predictor and random item streams
module arq_receiver_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arqrw_pkg::*;

  localparam logic [1:0] MODE_SR     = 2'd2;
  localparam logic [1:0] MODE_SR_ALT = 2'd3;
  localparam logic       OP_PACKET   = 1'b0;
  localparam logic       OP_TIMEOUT  = 1'b1;
  localparam int         SPACE       = 1024;
  localparam int         STALL_LIMIT = 5000;

  typedef struct packed {
    logic [LEN_W-1:0] data_length;
    logic [SEQ_W-1:0] seq_num;
    logic             packet_ok;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [STAT_W-1:0] bytes_total;
    logic [STAT_W-1:0] misorder_total;
    logic [STAT_W-1:0] corrupted_total;
    logic [STAT_W-1:0] packets_total;
    logic              finished;
    logic              misordered;
    logic [10:0]       expected_next;
    logic [CNT_W-1:0]  deliver_count;
    logic [SEQ_W-1:0]  deliver_first;
    logic [ACK_W-1:0]  ack_num;
    logic              ack_valid;
  } rx_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [2:0]       cfg_data = 3'd0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // predictor state
  logic [1:0]        mode_q = MODE_SW;
  logic [2:0]        limit_q = LIMIT_RESET;
  logic [10:0]       next_seq = '0;
  bit                seen_map [SPACE];
  logic [2:0]        timeout_run = '0;
  logic              done = 1'b0;
  logic [STAT_W-1:0] n_valid = '0;
  logic [STAT_W-1:0] n_bad = '0;
  logic [STAT_W-1:0] n_misorder = '0;
  logic [STAT_W-1:0] n_bytes = '0;

  rx_result_t window_results_due [$];
  int src_gap_pct = 0;
  int sink_gap_pct = 0;
  int sink_hold = 0;
  int errors = 0;
  int stall_cycles = 0;

  arq_receiver_window #(.SEQ_SPACE(SPACE)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [STAT_W-1:0] sat_inc32(logic [STAT_W-1:0] v);
    return (v == STAT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [STAT_W-1:0] sat_add32(logic [STAT_W-1:0] v, logic [LEN_W-1:0] a);
    logic [STAT_W:0] s;
    s = {1'b0, v} + (STAT_W + 1)'(a);
    return s[STAT_W] ? STAT_MAX : s[STAT_W-1:0];
  endfunction

  // step expected past every number already held
  function automatic logic [CNT_W-1:0] release_run();
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    while (next_seq < SPACE && seen_map[next_seq[SEQ_W-1:0]]) begin
      next_seq++;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic rx_result_t window_step(logic op, rx_item_t it);
    rx_result_t r;
    logic [10:0] seq;
    r = '0;
    seq = {1'b0, it.seq_num};
    if (!done) begin
      if (op == OP_TIMEOUT) begin
        if (mode_q == MODE_SW) begin
          if (timeout_run < RUN_MAX) timeout_run++;
          if (timeout_run >= ((limit_q == 3'd0) ? 3'd1 : limit_q)) done = 1'b1;
        end
      end else begin
        timeout_run = '0;
        if (!it.packet_ok) begin
          n_bad = sat_inc32(n_bad);
        end else begin
          n_valid = sat_inc32(n_valid);
          n_bytes = sat_add32(n_bytes, it.data_length);
          case (mode_q)
            MODE_SW: begin
              r.ack_valid = 1'b1;
              if (seq == next_seq) begin
                r.ack_num = seq;
                r.deliver_first = it.seq_num;
                r.deliver_count = CNT_W'(1);
                next_seq++;
              end else begin
                r.misordered = 1'b1;
                r.ack_num = next_seq - 1'b1;
              end
            end
            MODE_GBN: begin
              if (seq == next_seq) begin
                r.ack_valid = 1'b1;
                r.ack_num = seq;
                seen_map[it.seq_num] = 1'b1;
                r.deliver_first = it.seq_num;
                r.deliver_count = release_run();
              end else begin
                r.misordered = 1'b1;
                if (seq > next_seq) begin
                  r.ack_valid = 1'b1;
                  r.ack_num = next_seq - 1'b1;
                end
              end
            end
            default: begin
              r.ack_valid = 1'b1;
              r.ack_num = seq;
              if (seq >= next_seq) begin
                seen_map[it.seq_num] = 1'b1;
                r.deliver_first = next_seq[SEQ_W-1:0];
                r.deliver_count = release_run();
                if (r.deliver_count == 0) r.deliver_first = '0;
              end else begin
                r.misordered = 1'b1;
              end
            end
          endcase
          if (r.misordered) n_misorder = sat_inc32(n_misorder);
        end
      end
    end
    r.expected_next = next_seq;
    r.finished = done;
    r.packets_total = n_valid;
    r.corrupted_total = n_bad;
    r.misorder_total = n_misorder;
    r.bytes_total = n_bytes;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [STAT_W-1:0] got, logic [STAT_W-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result(rx_result_t got, rx_result_t want);
    check_field("ack_valid", STAT_W'(got.ack_valid), STAT_W'(want.ack_valid));
    check_field("ack_num", STAT_W'(got.ack_num), STAT_W'(want.ack_num));
    check_field("deliver_first", STAT_W'(got.deliver_first), STAT_W'(want.deliver_first));
    check_field("deliver_count", STAT_W'(got.deliver_count), STAT_W'(want.deliver_count));
    check_field("expected_next", STAT_W'(got.expected_next), STAT_W'(want.expected_next));
    check_field("misordered", STAT_W'(got.misordered), STAT_W'(want.misordered));
    check_field("finished", STAT_W'(got.finished), STAT_W'(want.finished));
    check_field("packets_total", got.packets_total, want.packets_total);
    check_field("corrupted_total", got.corrupted_total, want.corrupted_total);
    check_field("misorder_total", got.misorder_total, want.misorder_total);
    check_field("bytes_total", got.bytes_total, want.bytes_total);
    check_field("pad", STAT_W'(got.pad), STAT_W'(want.pad));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (window_results_due.size() == 0) flag_mismatch("result with no item pending");
      else begin
        check_result(rx_result_t'(m_tdata), window_results_due[0]);
        window_results_due.delete(0);
      end
    end
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic op, logic ok, int seq, int len);
    rx_item_t it;
    it.packet_ok = ok;
    it.seq_num = seq[SEQ_W-1:0];
    it.data_length = len[LEN_W-1:0];
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(IN_W - $bits(rx_item_t)){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
    window_results_due.push_back(window_step(op, it));
  endtask

  task automatic quiesce(int tail);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (window_results_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ARQ_MODE) mode_q = val[1:0];
    else limit_q = val;
  endtask

  task automatic send_packet(int seq, int len);
    send_item(OP_PACKET, 1'b1, seq, len);
  endtask

  task automatic send_timeout();
    send_item(OP_TIMEOUT, 1'($urandom_range(1)), $urandom_range(SPACE-1), $urandom_range(1023));
  endtask

  task automatic test_directed_cases();
    src_gap_pct = 20;
    sink_gap_pct = 20;
    send_packet(0, 0);
    send_timeout();
    send_packet(7, 1023);
    send_item(OP_PACKET, 1'b0, 1, 1023);
    send_packet(1, 1);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_GBN});
    send_packet(2, 17);
    send_packet(9, 3);
    send_packet(0, 0);
    send_timeout();
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SR});
    send_packet(5, 5);
    send_packet(4, 4);
    send_packet(3, 3);
    send_packet(1, 1);
    send_packet(1023, 1023);
    send_packet(8, 8);
    send_timeout();
    send_item(OP_PACKET, 1'b0, 6, 6);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SR_ALT});
    send_packet(6, 6);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_GBN});
    send_packet(7, 7);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SW});
    send_packet(9, 9);
    send_packet(1023, 1023);
    quiesce(4);
  endtask

  task automatic random_traffic(int n);
    int e, seq, roll, lim, len;
    logic op;
    for (int i = 0; i < n; i++) begin
      e = next_seq;
      lim = (limit_q == 3'd0) ? 1 : limit_q;
      op = OP_PACKET;
      // stop-and-wait timeouts stay short of the limit so reception goes on
      if ($urandom_range(99) < 10 && !(mode_q == MODE_SW && timeout_run + 1 >= lim))
        op = OP_TIMEOUT;
      roll = $urandom_range(99);
      if (roll < 20 || e >= SPACE) seq = $urandom_range(SPACE-1);
      else if (roll < 40) seq = e;
      else if (roll < 52 && e > 0) seq = $urandom_range(e-1);
      else begin
        seq = e + $urandom_range(12);
        if (seq >= SPACE) seq = SPACE - 1;
      end
      len = ($urandom_range(9) == 0) ? 1023 : $urandom_range(1023);
      send_item(op, $urandom_range(99) < 90, seq, len);
    end
  endtask

  task automatic test_random_traffic();
    logic [1:0] m;
    for (int p = 0; p < 3; p++) begin
      src_gap_pct = (p == 0) ? 33 : (p == 1) ? 49 : 0;
      sink_gap_pct = (p == 0) ? 49 : (p == 1) ? 33 : 0;
      for (int k = 0; k < 3; k++) begin
        m = k[1:0];
        if (k == 2 && $urandom_range(1)) m = MODE_SR_ALT;
        quiesce(4);
        write_reg(REG_ARQ_MODE, {1'b0, m});
        write_reg(REG_TIMEOUT_LIMIT, 3'($urandom_range(7, 1)));
        random_traffic(50);
      end
    end
    quiesce(4);
  endtask

  task automatic test_backpressure();
    write_reg(REG_ARQ_MODE, {1'b0, MODE_GBN});
    src_gap_pct = 0;
    sink_gap_pct = 20;
    sink_hold = 300;
    for (int i = 0; i < 16; i++) send_packet(int'(next_seq), $urandom_range(1023));
    // sender waits for every result before going on
    quiesce(0);
    for (int i = 0; i < 8; i++) send_packet(int'(next_seq) + $urandom_range(2), $urandom_range(1023));
    quiesce(4);
  endtask

  task automatic test_sequence_end();
    int base, n, j, tmp;
    int order [8];
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SR});
    src_gap_pct = 10;
    sink_gap_pct = 10;
    // shuffled runs just above expected, then the top of the space
    for (int run = 0; run < 2; run++) begin
      base = next_seq;
      n = 8;
      if (base + n > SPACE) n = SPACE - base;
      for (int i = 0; i < n; i++) order[i] = base + i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < n; i++) send_packet(order[i], $urandom_range(1023));
    end
    for (int i = 1; i <= 4; i++) send_packet(SPACE - i, i);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_GBN});
    send_packet(0, 2);
    send_packet(SPACE - 1, 3);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SW});
    send_packet(SPACE - 1, 4);
    send_packet(0, 5);
    quiesce(4);
  endtask

  task automatic test_reception_end();
    write_reg(REG_TIMEOUT_LIMIT, 3'd7);
    src_gap_pct = 33;
    sink_gap_pct = 33;
    repeat (6) send_timeout();
    send_item(OP_PACKET, 1'b0, 5, 5);
    repeat (6) send_timeout();
    send_packet(SPACE - 1, 0);
    quiesce(4);
    // a zero limit behaves as one
    write_reg(REG_TIMEOUT_LIMIT, 3'd0);
    send_timeout();
    send_packet(0, 1023);
    send_timeout();
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_GBN});
    send_packet(SPACE - 1, 9);
    quiesce(4);
    write_reg(REG_ARQ_MODE, {1'b0, MODE_SR});
    send_packet(3, 9);
    send_item(OP_PACKET, 1'b0, 3, 9);
    send_timeout();
    quiesce(4);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    test_sequence_end();
    test_reception_end();
    quiesce(32);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
